// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent checks with synchronous active-low reset qualification.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge outside reset.
`define ESC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Expression must never be true outside reset.
`define ESC_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ESC_ASSERT(lbl, clk, rst_n, prop)
`define ESC_ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// File: hdl/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types and constants for the epoch seconds to calendar converter.
// ----------------------------------------------------------------------------
package esc_pkg;

    localparam int unsigned EPOCH_W     = 32;
    localparam int unsigned DAYS_W      = 17;   // 49710 days at most
    localparam int unsigned YEAR_W      = 12;
    localparam int unsigned MON_W       = 4;
    localparam int unsigned MDAY_W      = 5;
    localparam int unsigned YLEN_W      = 9;

    localparam int unsigned EPOCH_YEAR  = 1970;
    localparam int unsigned MAX_YEAR    = 2106;
    localparam int unsigned EPOCH_Y4    = EPOCH_YEAR % 4;
    localparam int unsigned EPOCH_Y100  = EPOCH_YEAR % 100;
    localparam int unsigned EPOCH_Y400  = EPOCH_YEAR % 400;

    localparam int unsigned SIXTY         = 60;
    localparam int unsigned HOURS_PER_DAY = 24;
    localparam int unsigned DAYS_PER_WEEK = 7;
    localparam int unsigned WEEKDAY_OFFSET = 4;   // day 0 is a Thursday

    // Reciprocals rounded up; exact over the range each division sees
    localparam logic [31:0] RECIP_60       = 32'h8888_8889;
    localparam int unsigned RECIP_60_SHIFT = 37;
    localparam logic [31:0] RECIP_24       = 32'hAAAA_AAAB;
    localparam int unsigned RECIP_24_SHIFT = 36;
    localparam logic [31:0] RECIP_7        = 32'h9249_2493;
    localparam int unsigned RECIP_7_SHIFT  = 34;

    localparam int unsigned COMMON_YEAR_LEN = 365;
    localparam int unsigned LONG_YEAR_LEN   = 366;
    localparam int unsigned FEB_LEAP_LEN    = 29;

    localparam logic [MON_W-1:0] MON_FEB = 4'd1;
    localparam logic [MON_W-1:0] MON_DEC = 4'd11;

    localparam logic [MDAY_W-1:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef struct packed {
        logic [5:0]        second;
        logic [5:0]        minute;
        logic [4:0]        hour;
        logic [2:0]        weekday;
        logic [DAYS_W-1:0] days;
    } t_front_item;

    function automatic logic [MDAY_W-1:0] month_length(
        input logic [MON_W-1:0] mon,
        input logic             leap
    );
        logic [MDAY_W-1:0] len;
        len = MONTH_LEN[mon];
        if (mon == MON_FEB && leap) begin
            len = MDAY_W'(FEB_LEAP_LEN);
        end
        return len;
    endfunction

endpackage

// File: hdl/esc_front.sv
// ----------------------------------------------------------------------------
// esc_front
// Splits epoch seconds into second, minute, hour, day count and weekday
// with one shared reciprocal multiplier (multiply, then remainder).
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module esc_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [31:0]            i_epoch_seconds,
    output logic                   o_item_valid,
    input  logic                   i_item_ready,
    output esc_pkg::t_front_item   o_item
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_REM,
        S_PUSH
    } t_state;

    typedef enum logic [1:0] {
        PH_SEC,
        PH_MIN,
        PH_HOUR,
        PH_WDAY
    } t_phase;

    t_state                           r_state;
    t_phase                           r_phase;
    logic [esc_pkg::EPOCH_W-1:0]      r_num;
    logic [esc_pkg::EPOCH_W-1:0]      r_quot;
    esc_pkg::t_front_item             r_item;

    logic [5:0]                       w_divisor;
    logic [esc_pkg::EPOCH_W-1:0]      w_recip;
    logic [63:0]                      w_prod;
    logic [esc_pkg::EPOCH_W-1:0]      w_quot_next;
    logic [esc_pkg::EPOCH_W-1:0]      w_qd;
    logic [esc_pkg::EPOCH_W-1:0]      w_diff;

    always_comb begin
        case (r_phase)
            PH_SEC: begin
                w_divisor = 6'(esc_pkg::SIXTY);
                w_recip   = esc_pkg::RECIP_60;
            end
            PH_MIN: begin
                w_divisor = 6'(esc_pkg::SIXTY);
                w_recip   = esc_pkg::RECIP_60;
            end
            PH_HOUR: begin
                w_divisor = 6'(esc_pkg::HOURS_PER_DAY);
                w_recip   = esc_pkg::RECIP_24;
            end
            PH_WDAY: begin
                w_divisor = 6'(esc_pkg::DAYS_PER_WEEK);
                w_recip   = esc_pkg::RECIP_7;
            end
            default: begin
                w_divisor = 6'(esc_pkg::SIXTY);
                w_recip   = esc_pkg::RECIP_60;
            end
        endcase
    end

    // Unsigned 32 by 32 product; the high bits are the quotient
    assign w_prod = 64'(r_num) * 64'(w_recip);

    always_comb begin
        case (r_phase)
            PH_SEC:  w_quot_next = esc_pkg::EPOCH_W'(w_prod >> esc_pkg::RECIP_60_SHIFT);
            PH_MIN:  w_quot_next = esc_pkg::EPOCH_W'(w_prod >> esc_pkg::RECIP_60_SHIFT);
            PH_HOUR: w_quot_next = esc_pkg::EPOCH_W'(w_prod >> esc_pkg::RECIP_24_SHIFT);
            PH_WDAY: w_quot_next = esc_pkg::EPOCH_W'(w_prod >> esc_pkg::RECIP_7_SHIFT);
            default: w_quot_next = esc_pkg::EPOCH_W'(w_prod >> esc_pkg::RECIP_60_SHIFT);
        endcase
    end

    assign w_qd   = r_quot * esc_pkg::EPOCH_W'(w_divisor);
    assign w_diff = r_num - w_qd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_SEC;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_num   <= i_epoch_seconds;
                        r_phase <= PH_SEC;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_quot  <= w_quot_next;
                    r_state <= S_REM;
                end
                S_REM: begin
                    // the quotient carries on as the next numerator
                    case (r_phase)
                        PH_SEC: begin
                            r_item.second <= w_diff[5:0];
                            r_num         <= r_quot;
                            r_phase       <= PH_MIN;
                            r_state       <= S_MUL;
                        end
                        PH_MIN: begin
                            r_item.minute <= w_diff[5:0];
                            r_num         <= r_quot;
                            r_phase       <= PH_HOUR;
                            r_state       <= S_MUL;
                        end
                        PH_HOUR: begin
                            r_item.hour <= w_diff[4:0];
                            r_item.days <= r_quot[esc_pkg::DAYS_W-1:0];
                            // offset the day count so day 0 lands on Thursday
                            r_num   <= esc_pkg::EPOCH_W'(r_quot[esc_pkg::DAYS_W-1:0])
                                       + esc_pkg::EPOCH_W'(esc_pkg::WEEKDAY_OFFSET);
                            r_phase <= PH_WDAY;
                            r_state <= S_MUL;
                        end
                        PH_WDAY: begin
                            r_item.weekday <= w_diff[2:0] + 3'd1;
                            r_phase        <= PH_SEC;
                            r_state        <= S_PUSH;
                        end
                        default: begin
                            r_phase <= PH_SEC;
                            r_state <= S_IDLE;
                        end
                    endcase
                end
                S_PUSH: begin
                    if (i_item_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready      = (r_state == S_IDLE);
    assign o_item_valid = (r_state == S_PUSH);
    assign o_item       = r_item;

    `ESC_ASSERT(a_rem_range, i_clk, i_rst_n, (r_state == S_REM) |-> (w_diff < 32'(w_divisor)))

endmodule

// File: hdl/esc_fifo.sv
// ----------------------------------------------------------------------------
// esc_fifo
// Short queue decoupling the divider front from the calendar walk.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module esc_fifo #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_wr_valid,
    output logic                   o_wr_ready,
    input  esc_pkg::t_front_item   i_wr_item,
    output logic                   o_rd_valid,
    input  logic                   i_rd_ready,
    output esc_pkg::t_front_item   o_rd_item
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    esc_pkg::t_front_item  r_slot [DEPTH];
    logic [PTR_W-1:0]      r_wr_ptr;
    logic [PTR_W-1:0]      r_rd_ptr;
    logic [CNT_W-1:0]      r_count;

    logic                  w_push;
    logic                  w_pop;

    assign o_wr_ready = (r_count != CNT_W'(DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_item  = r_slot[r_rd_ptr];
    assign w_push     = i_wr_valid && o_wr_ready;
    assign w_pop      = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_wr_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `ESC_ASSERT(a_count_in_range, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH))
    `ESC_ASSERT(a_count_holds, i_clk, i_rst_n, (!w_push && !w_pop) |=> $stable(r_count))

endmodule

// File: hdl/esc_back.sv
// ----------------------------------------------------------------------------
// esc_back
// Walks whole years and then months over the day count, and holds the
// finished date until it is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module esc_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_item_valid,
    output logic                   o_item_ready,
    input  esc_pkg::t_front_item   i_item,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [5:0]             o_second,
    output logic [5:0]             o_minute,
    output logic [4:0]             o_hour,
    output logic [2:0]             o_weekday,
    output logic [11:0]            o_full_year,
    output logic [3:0]             o_month,
    output logic [4:0]             o_day_of_month
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_YEAR,
        S_MONTH,
        S_HOLD
    } t_state;

    localparam logic [esc_pkg::YEAR_W-1:0] LAST_YEAR = esc_pkg::YEAR_W'(esc_pkg::MAX_YEAR);

    t_state                          r_state;
    logic [esc_pkg::DAYS_W-1:0]      r_days;
    logic [esc_pkg::YEAR_W-1:0]      r_year;
    logic [1:0]                      r_y4;
    logic [6:0]                      r_y100;
    logic [8:0]                      r_y400;
    logic [esc_pkg::MON_W-1:0]       r_mon;
    logic [5:0]                      r_second;
    logic [5:0]                      r_minute;
    logic [4:0]                      r_hour;
    logic [2:0]                      r_weekday;
    logic [esc_pkg::MON_W-1:0]       r_month;
    logic [esc_pkg::MDAY_W-1:0]      r_mday;

    logic                            w_leap;
    logic [esc_pkg::YLEN_W-1:0]      w_ylen;
    logic [esc_pkg::MDAY_W-1:0]      w_mlen;
    logic                            w_bad_date;

    // Gregorian rule from running remainders of the year
    assign w_leap = (r_y4 == 2'd0) && ((r_y100 != 7'd0) || (r_y400 == 9'd0));
    assign w_ylen = w_leap ? esc_pkg::YLEN_W'(esc_pkg::LONG_YEAR_LEN)
                           : esc_pkg::YLEN_W'(esc_pkg::COMMON_YEAR_LEN);
    assign w_mlen = esc_pkg::month_length(r_mon, w_leap);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_item_valid) begin
                        r_second  <= i_item.second;
                        r_minute  <= i_item.minute;
                        r_hour    <= i_item.hour;
                        r_weekday <= i_item.weekday;
                        r_days    <= i_item.days;
                        r_year    <= esc_pkg::YEAR_W'(esc_pkg::EPOCH_YEAR);
                        r_y4      <= 2'(esc_pkg::EPOCH_Y4);
                        r_y100    <= 7'(esc_pkg::EPOCH_Y100);
                        r_y400    <= 9'(esc_pkg::EPOCH_Y400);
                        r_state   <= S_YEAR;
                    end
                end
                S_YEAR: begin
                    if (r_days < esc_pkg::DAYS_W'(w_ylen)) begin
                        r_mon   <= '0;
                        r_state <= S_MONTH;
                    end else begin
                        r_days <= r_days - esc_pkg::DAYS_W'(w_ylen);
                        r_year <= r_year + 1'b1;
                        r_y4   <= r_y4 + 1'b1;
                        r_y100 <= (r_y100 == 7'd99)  ? 7'd0 : r_y100 + 1'b1;
                        r_y400 <= (r_y400 == 9'd399) ? 9'd0 : r_y400 + 1'b1;
                    end
                end
                S_MONTH: begin
                    // December always ends the walk
                    if ((r_mon == esc_pkg::MON_DEC) ||
                        (r_days < esc_pkg::DAYS_W'(w_mlen))) begin
                        r_month <= r_mon + 1'b1;
                        r_mday  <= r_days[esc_pkg::MDAY_W-1:0] + 1'b1;
                        r_state <= S_HOLD;
                    end else begin
                        r_days <= r_days - esc_pkg::DAYS_W'(w_mlen);
                        r_mon  <= r_mon + 1'b1;
                    end
                end
                S_HOLD: begin
                    if (i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_item_ready   = (r_state == S_IDLE);
    assign o_valid        = (r_state == S_HOLD);
    assign o_second       = r_second;
    assign o_minute       = r_minute;
    assign o_hour         = r_hour;
    assign o_weekday      = r_weekday;
    assign o_full_year    = r_year;
    assign o_month        = r_month;
    assign o_day_of_month = r_mday;

    assign w_bad_date = (r_month == 4'd0) || (r_month > 4'd12) || (r_mday == 5'd0);

    `ESC_ASSERT(a_year_bound, i_clk, i_rst_n, (r_state == S_YEAR) |-> (r_year <= LAST_YEAR))
    `ESC_ASSERT(a_month_bound, i_clk, i_rst_n, (r_state == S_MONTH) |-> (r_mon <= esc_pkg::MON_DEC))
    `ESC_ASSERT_NEVER(a_bad_date, i_clk, i_rst_n, (r_state == S_HOLD) && w_bad_date)

endmodule

// File: hdl/epoch_seconds_to_calendar.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar
// Converts unsigned seconds since 1970-01-01 00:00:00 to time of day,
// weekday and Gregorian date.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  input    | i_valid / o_ready  | i_epoch_seconds
//  output   | o_valid / i_ready  | o_second o_minute o_hour o_weekday
//           |                    | o_full_year o_month o_day_of_month
//
//  Front: accept, four divisions by 60, 60, 24 and 7 (reciprocal multiply,
//  then remainder) on one multiplier, hand-off; it takes no new count before
//  the hand-off. Back: walks the years past 1970, then the months, then holds
//  the date until it is taken. The queue holds QUEUE_DEPTH items, so either
//  side stalls alone. Reset clears control state only.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_epoch_seconds,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [5:0]  o_second,
    output logic [5:0]  o_minute,
    output logic [4:0]  o_hour,
    output logic [2:0]  o_weekday,
    output logic [11:0] o_full_year,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day_of_month
);

    logic                  w_fr_valid;
    logic                  w_fr_ready;
    esc_pkg::t_front_item  w_fr_item;
    logic                  w_bk_valid;
    logic                  w_bk_ready;
    esc_pkg::t_front_item  w_bk_item;

    esc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_epoch_seconds (i_epoch_seconds),
        .o_item_valid    (w_fr_valid),
        .i_item_ready    (w_fr_ready),
        .o_item          (w_fr_item)
    );

    esc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (w_fr_valid),
        .o_wr_ready (w_fr_ready),
        .i_wr_item  (w_fr_item),
        .o_rd_valid (w_bk_valid),
        .i_rd_ready (w_bk_ready),
        .o_rd_item  (w_bk_item)
    );

    esc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item_valid   (w_bk_valid),
        .o_item_ready   (w_bk_ready),
        .i_item         (w_bk_item),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_second       (o_second),
        .o_minute       (o_minute),
        .o_hour         (o_hour),
        .o_weekday      (o_weekday),
        .o_full_year    (o_full_year),
        .o_month        (o_month),
        .o_day_of_month (o_day_of_month)
    );

endmodule

// File: bench/calendar_check_pkg.sv
// ----------------------------------------------------------------------------
// calendar_check_pkg
// Calendar arithmetic for the bench and a scoreboard that predicts each date
// from its seconds count and checks it against the converter's results.
// ----------------------------------------------------------------------------
package calendar_check_pkg;

    import esc_pkg::*;

    typedef struct packed {
        logic [5:0]        second;
        logic [5:0]        minute;
        logic [4:0]        hour;
        logic [2:0]        weekday;
        logic [YEAR_W-1:0] full_year;
        logic [MON_W-1:0]  month;
        logic [MDAY_W-1:0] day_of_month;
    } calendar_t;

    function automatic bit has_leap_day(int unsigned y);
        if (y % 4 != 0) return 1'b0;
        if (y % 100 != 0) return 1'b1;
        return (y % 400) == 0;
    endfunction

    function automatic int unsigned year_days(int unsigned y);
        return has_leap_day(y) ? 366 : 365;
    endfunction

    // mon0 counts from 0 for January
    function automatic int unsigned days_in_month(int unsigned mon0, int unsigned y);
        int unsigned lens [12];
        lens = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        if (mon0 == 1 && has_leap_day(y)) return 29;
        return lens[mon0];
    endfunction

    // Seconds count of a calendar date; may fall outside 32 bits.
    function automatic longint seconds_at(int unsigned y, int unsigned m, int unsigned d,
                                          int unsigned h, int unsigned mi, int unsigned s);
        longint total;
        total = 0;
        for (int unsigned yy = 1970; yy < y; yy++) total += year_days(yy);
        for (int unsigned mm = 0; mm + 1 < m; mm++) total += days_in_month(mm, y);
        total += d - 1;
        return ((total * 24 + h) * 60 + mi) * 60 + s;
    endfunction

    class calendar_scoreboard;
        calendar_t awaited [$];
        int        mismatches;
        int        checked;

        function new();
            mismatches = 0;
            checked    = 0;
        endfunction

        function calendar_t date_of(logic [31:0] secs);
            int unsigned t;
            int unsigned days;
            int unsigned year;
            int unsigned mon;
            calendar_t   r;
            t        = secs;
            r.second = 6'(t % 60);
            t        = t / 60;
            r.minute = 6'(t % 60);
            t        = t / 60;
            r.hour   = 5'(t % 24);
            days     = t / 24;
            r.weekday = 3'(((days + 4) % 7) + 1);
            year = 1970;
            while (days >= year_days(year)) begin
                days -= year_days(year);
                year++;
            end
            mon = 0;
            while (mon < 12 && days >= days_in_month(mon, year)) begin
                days -= days_in_month(mon, year);
                mon++;
            end
            if (mon > 11) mon = 11;
            r.full_year    = YEAR_W'(year);
            r.month        = MON_W'(mon + 1);
            r.day_of_month = MDAY_W'(days + 1);
            return r;
        endfunction

        function void note_input(logic [31:0] secs);
            awaited.push_back(date_of(secs));
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        task report(string what);
            $display("MISMATCH after %0d results: %s", checked, what);
            mismatches++;
        endtask

        task compare_field(string name, int unsigned got, int unsigned want);
            if (got != want) report($sformatf("%s is %0d, want %0d", name, got, want));
        endtask

        task check_result(calendar_t got);
            calendar_t want;
            if (awaited.size() == 0) begin
                report("result arrived with no item outstanding");
                return;
            end
            want = awaited.pop_front();
            compare_field("second", got.second, want.second);
            compare_field("minute", got.minute, want.minute);
            compare_field("hour", got.hour, want.hour);
            compare_field("weekday", got.weekday, want.weekday);
            compare_field("full_year", got.full_year, want.full_year);
            compare_field("month", got.month, want.month);
            compare_field("day_of_month", got.day_of_month, want.day_of_month);
            checked++;
        endtask
    endclass

endpackage

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives seconds counts into the epoch to calendar converter under random
// idling on both channels and checks every date against a local prediction.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import esc_pkg::*;
    import calendar_check_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam int unsigned TAIL_CYCLES = 400;
    localparam int unsigned PHASE_ITEMS = 510;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [31:0] i_epoch_seconds;
    logic        o_valid;
    logic        i_ready;
    logic [5:0]  o_second;
    logic [5:0]  o_minute;
    logic [4:0]  o_hour;
    logic [2:0]  o_weekday;
    logic [11:0] o_full_year;
    logic [3:0]  o_month;
    logic [4:0]  o_day_of_month;

    calendar_scoreboard sb;
    int unsigned        tx_idle_pct;
    int unsigned        rx_idle_pct;
    logic               rx_hold;
    int unsigned        cycle_count;
    int unsigned        items_sent;

    epoch_seconds_to_calendar dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_epoch_seconds (i_epoch_seconds),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_second        (o_second),
        .o_minute        (o_minute),
        .o_hour          (o_hour),
        .o_weekday       (o_weekday),
        .o_full_year     (o_full_year),
        .o_month         (o_month),
        .o_day_of_month  (o_day_of_month)
    );

    initial begin
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_ready         = 1'b0;
        i_epoch_seconds = '0;
        rx_hold         = 1'b0;
        cycle_count     = 0;
        items_sent      = 0;
        tx_idle_pct     = 0;
        rx_idle_pct     = 0;
        sb              = new();
    end

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.pending());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result side: values read here are those from before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_result(calendar_t'{o_second, o_minute, o_hour, o_weekday,
                                        o_full_year, o_month, o_day_of_month});
        end
        i_ready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
    end

    task automatic send_item(logic [31:0] secs);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_epoch_seconds <= secs;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_input(secs);
        items_sent++;
    endtask

    task automatic hold_receiver(int unsigned cycles);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (cycles) @(posedge i_clk);
        rx_hold <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Dates at month and year edges, around midnight, a few seconds either side.
    function automatic logic [31:0] edge_date();
        int unsigned y;
        int unsigned m;
        int unsigned d;
        longint      total;
        y = $urandom_range(1970, 2106);
        if ($urandom_range(0, 3) == 0) y = $urandom_range(2099, 2101);
        m = $urandom_range(1, 12);
        d = $urandom_range(0, 1) ? 1 : days_in_month(m - 1, y);
        if ($urandom_range(0, 1))
            total = seconds_at(y, m, d, 0, 0, 0);
        else
            total = seconds_at(y, m, d, 23, 59, 59);
        total += $urandom_range(0, 4);
        total -= 2;
        if (total < 0 || total > longint'(32'hFFFF_FFFF)) return $urandom();
        return 32'(total);
    endfunction

    function automatic logic [31:0] random_epoch();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) return $urandom();
        if (pick < 80) return edge_date();
        if (pick < 90) return $urandom_range(0, 200_000);
        return 32'hFFFF_FFFF - $urandom_range(0, 2_000_000);
    endfunction

    task automatic run_phase(int unsigned tx_pct, int unsigned rx_pct, bit stall_rx,
                             bit pause_tx);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (stall_rx && n == 100) begin
                fork
                    hold_receiver(3000);
                join_none
            end
            // Let everything drain before carrying on.
            if (pause_tx && n == PHASE_ITEMS / 2) begin
                i_valid <= 1'b0;
                wait_drained();
            end
            send_item(random_epoch());
        end
    endtask

    initial begin
        logic [31:0] directed [$];
        int unsigned tail;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed = '{32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399,
                     32'h7FFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555,
                     32'hFFFF_FFFE, 32'hFFFF_FFFF};
        // One item per weekday, starting on the epoch's Thursday.
        for (int d = 0; d < 7; d++) directed.push_back(32'(43200 + d * 86400));
        directed.push_back(32'(seconds_at(1972, 2, 29, 12, 0, 0)));
        directed.push_back(32'(seconds_at(1972, 12, 31, 23, 59, 59)));
        directed.push_back(32'(seconds_at(2000, 2, 29, 0, 0, 0)));
        directed.push_back(32'(seconds_at(2100, 2, 28, 23, 59, 59)));
        directed.push_back(32'(seconds_at(2100, 3, 1, 0, 0, 0)));

        tx_idle_pct = 20;
        rx_idle_pct = 20;
        foreach (directed[k]) send_item(directed[k]);
        i_valid <= 1'b0;
        wait_drained();

        run_phase(38, 51, 1'b1, 1'b0);
        i_valid <= 1'b0;
        wait_drained();
        run_phase(51, 38, 1'b0, 1'b0);
        i_valid <= 1'b0;
        wait_drained();
        run_phase(0, 0, 1'b0, 1'b1);
        i_valid <= 1'b0;
        wait_drained();

        tail = 0;
        while (tail < TAIL_CYCLES) begin
            @(posedge i_clk);
            tail++;
        end
        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));

        $display("Converted %0d seconds counts, %0d dates checked, %0d mismatches",
                 items_sent, sb.checked, sb.mismatches);
        $display("Covered field extremes, leap and century years, month edges and stalls");
        if (sb.mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+hdl
hdl/esc_pkg.sv
hdl/esc_front.sv
hdl/esc_fifo.sv
hdl/esc_back.sv
hdl/epoch_seconds_to_calendar.sv
bench/calendar_check_pkg.sv
bench/testbench.sv
